@@ hw/rtl/idiv_pkg.sv @@
// package with shared types and constants of the 64-bit integer divider
`default_nettype none
package idiv_pkg;

  localparam int FULL_WIDTH = 64;

  typedef enum logic [1:0] {
    FUNC_UQUO = 2'd0,
    FUNC_UREM = 2'd1,
    FUNC_SQUO = 2'd2,
    FUNC_SREM = 2'd3
  } func_t;

  typedef struct packed {
    logic valid;
    logic rem_sel;
    logic negate;
  } ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/idiv_op_if.sv @@
// operation channel interface: function code and operands
`default_nettype none
interface idiv_op_if;
  logic                                  valid;
  logic                                  ready;
  idiv_pkg::func_t                       func;
  logic [idiv_pkg::FULL_WIDTH-1:0]       dividend;
  logic [idiv_pkg::FULL_WIDTH-1:0]       divisor;

  modport source (output valid, func, dividend, divisor, input ready);
  modport sink (input valid, func, dividend, divisor, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/idiv_res_if.sv @@
// result channel interface
`default_nettype none
interface idiv_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [idiv_pkg::FULL_WIDTH-1:0]       result;

  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/integer_divider_64_unit.sv @@
// top level of the pipelined 64-bit restoring integer divider
//
//   channel  role    payload
//   op       sink    func, dividend, divisor
//   res      source  result
//
// one transaction accepted per cycle while the skid register is empty; the result passes through
// the input stage, one cell per quotient bit and the output stage
// a skid register behind the output stage takes a result that is not taken;
// while it is full the whole cell chain holds and op.ready is low
// synchronous reset clears all valid bits; payload registers are not reset
`default_nettype none
module integer_divider_64_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  idiv_op_if.sink          op,
  idiv_res_if.source       res
);

  localparam int W  = DATA_WIDTH;
  localparam int FW = idiv_pkg::FULL_WIDTH;

  idiv_pkg::ctl_t ctl_s [0:W];
  logic [W-1:0]   rem_s [0:W];
  logic [W-1:0]   nq_s  [0:W];
  logic [W-1:0]   dvs_s [0:W];

  logic           adv;
  logic           p_valid;
  logic [W-1:0]   p_result;
  logic           sv;
  logic [W-1:0]   skid_result;

  assign adv      = ~sv;
  assign op.ready = adv;
  assign rem_s[0] = '0;

  idiv_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (op.valid),
    .func     (op.func),
    .dividend (op.dividend[W-1:0]),
    .divisor  (op.divisor[W-1:0]),
    .ctl      (ctl_s[0]),
    .nq       (nq_s[0]),
    .dvs      (dvs_s[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_cell
    idiv_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (ctl_s[k]),
      .rem_in  (rem_s[k]),
      .nq_in   (nq_s[k]),
      .dvs_in  (dvs_s[k]),
      .ctl_out (ctl_s[k+1]),
      .rem_out (rem_s[k+1]),
      .nq_out  (nq_s[k+1]),
      .dvs_out (dvs_s[k+1])
    );
  end

  idiv_post #(.W(W)) u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .ctl_in (ctl_s[W]),
    .rem_in (rem_s[W]),
    .quo_in (nq_s[W]),
    .valid  (p_valid),
    .result (p_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (sv) begin
      if (res.ready) begin
        sv <= 1'b0;
      end
    end else if (p_valid && !res.ready) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sv) begin
      skid_result <= p_result;
    end
  end

  assign res.valid  = sv | p_valid;
  assign res.result = FW'(sv ? skid_result : p_result);

`ifndef SYNTHESIS
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    sv && !res.ready |=> sv)
    else $error("skid register dropped an untaken transaction");

  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(p_valid) && $stable(p_result))
    else $error("output stage moved while the chain was held");

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ((res.result >> DATA_WIDTH) == '0))
    else $error("result bits above the data width are not zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/idiv_prep.sv @@
// input stage: operand magnitudes and result sign control
`default_nettype none
module idiv_prep #(
  parameter int W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire idiv_pkg::func_t   func,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [W-1:0]      divisor,
  output idiv_pkg::ctl_t         ctl,
  output logic [W-1:0]           nq,
  output logic [W-1:0]           dvs
);

  logic         valid;
  logic         rem_sel;
  logic         negate;
  logic         is_signed;
  logic         na;
  logic         nb;
  logic [W-1:0] ma;
  logic [W-1:0] mb;

  always_comb begin
    is_signed = (func == idiv_pkg::FUNC_SQUO) || (func == idiv_pkg::FUNC_SREM);
    na = is_signed & dividend[W-1];
    nb = is_signed & divisor[W-1];
    ma = na ? (W'(0) - dividend) : dividend;
    mb = nb ? (W'(0) - divisor) : divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_sel <= (func == idiv_pkg::FUNC_UREM) || (func == idiv_pkg::FUNC_SREM);
      negate  <= ((func == idiv_pkg::FUNC_UREM) || (func == idiv_pkg::FUNC_SREM)) ?
                 na : (na ^ nb);
      nq      <= ma;
      dvs     <= mb;
    end
  end

  assign ctl = '{valid: valid, rem_sel: rem_sel, negate: negate};

endmodule
`default_nettype wire

@@ hw/rtl/idiv_cell.sv @@
// one restoring shift-and-subtract step with its stage register
`default_nettype none
module idiv_cell #(
  parameter int W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire idiv_pkg::ctl_t    ctl_in,
  input  wire logic [W-1:0]      rem_in,
  input  wire logic [W-1:0]      nq_in,
  input  wire logic [W-1:0]      dvs_in,
  output idiv_pkg::ctl_t         ctl_out,
  output logic [W-1:0]           rem_out,
  output logic [W-1:0]           nq_out,
  output logic [W-1:0]           dvs_out
);

  logic         valid;
  logic         rem_sel;
  logic         negate;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] rem_next;
  logic [W-1:0] nq_next;

  // partial remainder shifted up with the next dividend bit, carry kept on top
  always_comb begin
    trial    = {rem_in, nq_in[W-1]};
    diff     = trial - {1'b0, dvs_in};
    take     = ~diff[W];
    rem_next = take ? diff[W-1:0] : trial[W-1:0];
    nq_next  = {nq_in[W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_sel <= ctl_in.rem_sel;
      negate  <= ctl_in.negate;
      rem_out <= rem_next;
      nq_out  <= nq_next;
      dvs_out <= dvs_in;
    end
  end

  assign ctl_out = '{valid: valid, rem_sel: rem_sel, negate: negate};

endmodule
`default_nettype wire

@@ hw/rtl/idiv_post.sv @@
// output stage: quotient or remainder select and sign fix-up
`default_nettype none
module idiv_post #(
  parameter int W = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire idiv_pkg::ctl_t    ctl_in,
  input  wire logic [W-1:0]      rem_in,
  input  wire logic [W-1:0]      quo_in,
  output logic                   valid,
  output logic [W-1:0]           result
);

  logic [W-1:0] sel;
  logic [W-1:0] fixed;

  always_comb begin
    sel   = ctl_in.rem_sel ? rem_in : quo_in;
    fixed = ctl_in.negate ? (W'(0) - sel) : sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= fixed;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/idiv_result_checker.sv @@
// result checker for the integer divider: predicts each accepted operation and compares results
`timescale 1ns / 1ps
module idiv_result_checker (
  input  logic        clk,
  input  logic        rst,
  idiv_op_if          op,
  idiv_res_if         res,
  output int unsigned pending,
  output int unsigned mismatches
);

  localparam int W = idiv_pkg::FULL_WIDTH;

  typedef struct {
    idiv_pkg::func_t func;
    logic [W-1:0]    dividend;
    logic [W-1:0]    divisor;
    logic [W-1:0]    result;
  } div_case_t;

  div_case_t expected_results[$];

  function automatic logic [W-1:0] shift_subtract_divide(input logic [W-1:0] num,
                                                         input logic [W-1:0] den,
                                                         input logic want_rem);
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    logic [W:0]   part;
    quo = '0;
    rem = '0;
    for (int i = W - 1; i >= 0; i--) begin
      part = {rem, num[i]};
      if (part >= {1'b0, den}) begin
        part = part - {1'b0, den};
        quo[i] = 1'b1;
      end
      rem = part[W-1:0];
    end
    return want_rem ? rem : quo;
  endfunction

  function automatic logic [W-1:0] divide_result(input idiv_pkg::func_t f,
                                                 input logic [W-1:0] a,
                                                 input logic [W-1:0] b);
    logic         signed_op;
    logic         want_rem;
    logic         neg_a;
    logic         neg_b;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] value;
    signed_op = (f == idiv_pkg::FUNC_SQUO) || (f == idiv_pkg::FUNC_SREM);
    want_rem  = (f == idiv_pkg::FUNC_UREM) || (f == idiv_pkg::FUNC_SREM);
    neg_a = signed_op && a[W-1];
    neg_b = signed_op && b[W-1];
    mag_a = neg_a ? -a : a;
    mag_b = neg_b ? -b : b;
    value = shift_subtract_divide(mag_a, mag_b, want_rem);
    // remainder follows the dividend sign, quotient the sign difference
    if (want_rem ? neg_a : (neg_a != neg_b))
      value = -value;
    return value;
  endfunction

  always @(posedge clk) begin
    div_case_t head;
    if (rst) begin
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t unexpected result: expected none actual %h", $time, res.result);
        end else begin
          head = expected_results.pop_front();
          if (res.result !== head.result) begin
            mismatches <= mismatches + 1;
            $display("%0t mismatch %s %h / %h: expected %h actual %h", $time,
                     head.func.name(), head.dividend, head.divisor, head.result, res.result);
          end
        end
      end
      if (op.valid && op.ready)
        expected_results.push_back('{op.func, op.dividend, op.divisor,
                                     divide_result(op.func, op.dividend, op.divisor)});
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// testbench top for the integer divider: clock, reset, operation stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb;

  localparam int W = idiv_pkg::FULL_WIDTH;
  localparam int LATENCY = W + 2;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int NUM_PHASES = 8;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = '1;

  logic        clk;
  logic        rst;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        op_taken;
  int unsigned quiet_cycles;

  idiv_op_if  op();
  idiv_res_if res();

  integer_divider_64_unit #(
    .DATA_WIDTH(W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .op(op),
    .res(res)
  );

  idiv_result_checker result_check (
    .clk(clk),
    .rst(rst),
    .op(op),
    .res(res),
    .pending(pending),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    op_taken <= op.valid && op.ready;
    if (rst || (op.valid && op.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    int unsigned  pick;
    int unsigned  width;
    v = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    case (pick)
      0: v = '0;
      1: v = W'(1);
      2: v = ALL_ONES;
      3: v = MOST_NEG;
      4: v = MOST_POS;
      default: begin
        width = $urandom_range(1, W);
        v = v & (ALL_ONES >> (W - width));
        if (pick >= 12)
          v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_op(input idiv_pkg::func_t f, input logic [W-1:0] a,
                         input logic [W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      op.valid <= 1'b0;
      @(negedge clk);
    end
    op.valid    <= 1'b1;
    op.func     <= f;
    op.dividend <= a;
    op.divisor  <= b;
    do @(negedge clk); while (!op_taken);
  endtask

  initial begin
    logic [W-1:0] dir_a [6];
    logic [W-1:0] dir_b [6];
    op.valid    = 1'b0;
    op.func     = idiv_pkg::FUNC_UQUO;
    op.dividend = '0;
    op.divisor  = '0;
    rst = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // most negative by minus one, zero divisors, mixed signs, zero dividend
    dir_a = '{MOST_NEG, ALL_ONES, MOST_POS, 64'hFFFF_FFFF_FFFF_FFF9, 64'd7, 64'd0};
    dir_b = '{ALL_ONES, 64'd0, 64'd0, 64'd2, 64'hFFFF_FFFF_FFFF_FFFE, MOST_NEG};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int c = 0; c < 6; c++) begin
      for (int f = 0; f < 4; f++) begin
        send_op(idiv_pkg::func_t'(f), dir_a[c], dir_b[c]);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        send_op(idiv_pkg::func_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
      end
      // hold off until the pipeline has drained
      op.valid <= 1'b0;
      do @(negedge clk); while (pending != 0);
    end

    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ integer_divider_64_unit.f @@
hw/rtl/idiv_pkg.sv
hw/rtl/idiv_op_if.sv
hw/rtl/idiv_res_if.sv
hw/rtl/idiv_prep.sv
hw/rtl/idiv_cell.sv
hw/rtl/idiv_post.sv
hw/rtl/integer_divider_64_unit.sv
tb/sv/idiv_result_checker.sv
tb/sv/tb.sv
